// ===== hdl/lrp_pkg.sv =====
// Shared types, constants and tables for the lidar range-to-projection block.
`default_nettype none

package lrp_pkg;

    // Parameter defaults.
    localparam int IMAGE_WIDTH_DEFAULT      = 1024;
    localparam int MAX_IMAGE_HEIGHT_DEFAULT = 1024;

    // Configuration channel widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Width of the clamped scan length and image height values.
    localparam int DIM_W = 13;

    // Iteration counts: the divider sets the length of the shared loop.
    localparam int CORDIC_STEPS = 20;
    localparam int DIV_STEPS    = 32;
    localparam int ITER_W       = $clog2(DIV_STEPS);

    // Angle constants in Q20 radians.
    localparam logic signed [24:0] PI_Q20      = 25'sd3294199;
    localparam logic signed [24:0] TWO_PI_Q20  = 25'sd6588397;
    localparam logic signed [24:0] HALF_PI_Q20 = 25'sd1647099;

    // CORDIC start vector length (gain-compensated, Q30).
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032875;

    // Degrees per radian in Q16.
    localparam logic [22:0] DEG_Q16 = 23'd3754936;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLES_PER_SCAN    = 3'd0,
        REG_SCAN_START_ANGLE    = 3'd1,
        REG_SCAN_ANGLE_STEP     = 3'd2,
        REG_MAX_RANGE           = 3'd3,
        REG_STEPPER_START_ANGLE = 3'd4,
        REG_STEPPER_ANGLE_STEP  = 3'd5,
        REG_ENDSTOP_ANGLE       = 3'd6,
        REG_IMAGE_HEIGHT        = 3'd7
    } cfg_index_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_ITER,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_ROUND,
        ST_CHECK,
        ST_FINISH
    } lrp_state_t;

    // Configuration register contents.
    typedef struct packed {
        logic [10:0] samples_per_scan;
        logic [23:0] scan_start_angle;
        logic [23:0] scan_angle_step;
        logic [15:0] max_range;
        logic [23:0] stepper_start_angle;
        logic [23:0] stepper_angle_step;
        logic [23:0] endstop_angle;
        logic [10:0] image_height;
    } lrp_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              reduce;
        logic              iter;
        logic [ITER_W-1:0] iter_idx;
        logic              mul;
        logic              sum;
        logic              scale;
        logic              round;
        logic              check;
        logic              emit;
        logic              advance;
    } lrp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
    } lrp_status_t;

    // Arctangent of 2^-i in Q20 radians.
    function automatic logic signed [24:0] atan_q20(input logic [ITER_W-1:0] idx);
        logic signed [24:0] val;
        begin
            case (idx)
                5'd0:    val = 25'sd823550;
                5'd1:    val = 25'sd486170;
                5'd2:    val = 25'sd256879;
                5'd3:    val = 25'sd130396;
                5'd4:    val = 25'sd65451;
                5'd5:    val = 25'sd32757;
                5'd6:    val = 25'sd16383;
                5'd7:    val = 25'sd8192;
                5'd8:    val = 25'sd4096;
                5'd9:    val = 25'sd2048;
                5'd10:   val = 25'sd1024;
                5'd11:   val = 25'sd512;
                5'd12:   val = 25'sd256;
                5'd13:   val = 25'sd128;
                5'd14:   val = 25'sd64;
                5'd15:   val = 25'sd32;
                5'd16:   val = 25'sd16;
                5'd17:   val = 25'sd8;
                5'd18:   val = 25'sd4;
                5'd19:   val = 25'sd2;
                default: val = 25'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lrp_if.sv =====
// Channel interfaces: range samples in, pixel writes out, configuration writes in.
`default_nettype none

// Range sample channel.
interface lrp_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] range_sample;
    logic        last_in_frame;

    modport source (output valid, output range_sample, output last_in_frame, input ready);
    modport sink   (input valid, input range_sample, input last_in_frame, output ready);
endinterface

// Pixel write channel.
interface lrp_pixel_if;
    logic        valid;
    logic        ready;
    logic [9:0]  pixel_row;
    logic [9:0]  pixel_column;
    logic [15:0] pixel_value;

    modport source (output valid, output pixel_row, output pixel_column, output pixel_value,
                    input ready);
    modport sink   (input valid, input pixel_row, input pixel_column, input pixel_value,
                    output ready);
endinterface

// Configuration write channel.
interface lrp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lrp_pkg::CFG_IDX_W-1:0]  index;
    logic [lrp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/lrp_cfg_regs.sv =====
// Configuration register file for the lidar range-to-projection block.
`default_nettype none

module lrp_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_valid,
    input  wire logic [lrp_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [lrp_pkg::CFG_DATA_W-1:0] wr_data,
    output logic                                wr_ready,
    output lrp_pkg::lrp_cfg_t                   cfg
);

    lrp_pkg::lrp_cfg_t cfg_reg;
    lrp_pkg::lrp_cfg_t cfg_next;

    // Writes are always taken.
    assign wr_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the register index of a write word.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            case (lrp_pkg::cfg_index_t'(wr_index))
                lrp_pkg::REG_SAMPLES_PER_SCAN:    cfg_next.samples_per_scan    = wr_data[10:0];
                lrp_pkg::REG_SCAN_START_ANGLE:    cfg_next.scan_start_angle    = wr_data;
                lrp_pkg::REG_SCAN_ANGLE_STEP:     cfg_next.scan_angle_step     = wr_data;
                lrp_pkg::REG_MAX_RANGE:           cfg_next.max_range           = wr_data[15:0];
                lrp_pkg::REG_STEPPER_START_ANGLE: cfg_next.stepper_start_angle = wr_data;
                lrp_pkg::REG_STEPPER_ANGLE_STEP:  cfg_next.stepper_angle_step  = wr_data;
                lrp_pkg::REG_ENDSTOP_ANGLE:       cfg_next.endstop_angle       = wr_data;
                lrp_pkg::REG_IMAGE_HEIGHT:        cfg_next.image_height        = wr_data[10:0];
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_scan    <= 11'd1024;
            cfg_reg.scan_start_angle    <= '0;
            cfg_reg.scan_angle_step     <= '0;
            cfg_reg.max_range           <= 16'hFFFF;
            cfg_reg.stepper_start_angle <= '0;
            cfg_reg.stepper_angle_step  <= '0;
            cfg_reg.endstop_angle       <= '0;
            cfg_reg.image_height        <= 11'd1024;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lrp_ctrl.sv =====
// Controller state machine that sequences one sample through the datapath.
`default_nettype none

module lrp_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire lrp_pkg::lrp_status_t  status,
    output lrp_pkg::lrp_cmd_t          cmd
);

    localparam logic [lrp_pkg::ITER_W-1:0] ITER_LAST = lrp_pkg::ITER_W'(lrp_pkg::DIV_STEPS - 1);

    lrp_pkg::lrp_state_t            state_reg;
    lrp_pkg::lrp_state_t            state_next;
    logic [lrp_pkg::ITER_W-1:0]     iter_reg;
    logic [lrp_pkg::ITER_W-1:0]     iter_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           finish_go;

    // The last step may only run when the output register is free or is being drained.
    assign finish_go = (state_reg == lrp_pkg::ST_FINISH) && (!out_valid_reg || out_ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrp_pkg::ST_IDLE:
                if (in_valid)
                    state_next = lrp_pkg::ST_REDUCE;
            lrp_pkg::ST_REDUCE: state_next = lrp_pkg::ST_ITER;
            lrp_pkg::ST_ITER:
                if (iter_reg == ITER_LAST)
                    state_next = lrp_pkg::ST_MUL;
            lrp_pkg::ST_MUL:    state_next = lrp_pkg::ST_SUM;
            lrp_pkg::ST_SUM:    state_next = lrp_pkg::ST_SCALE;
            lrp_pkg::ST_SCALE:  state_next = lrp_pkg::ST_ROUND;
            lrp_pkg::ST_ROUND:  state_next = lrp_pkg::ST_CHECK;
            lrp_pkg::ST_CHECK:  state_next = lrp_pkg::ST_FINISH;
            lrp_pkg::ST_FINISH:
                if (finish_go)
                    state_next = lrp_pkg::ST_IDLE;
            default:            state_next = lrp_pkg::ST_IDLE;
        endcase
    end

    // Commands, handshake and iteration counter.
    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        iter_next      = iter_reg;
        cmd.iter_idx   = iter_reg;
        case (state_reg)
            lrp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            lrp_pkg::ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                iter_next  = '0;
            end
            lrp_pkg::ST_ITER:
            begin
                cmd.iter  = 1'b1;
                iter_next = iter_reg + 1'b1;
            end
            lrp_pkg::ST_MUL:   cmd.mul   = 1'b1;
            lrp_pkg::ST_SUM:   cmd.sum   = 1'b1;
            lrp_pkg::ST_SCALE: cmd.scale = 1'b1;
            lrp_pkg::ST_ROUND: cmd.round = 1'b1;
            lrp_pkg::ST_CHECK: cmd.check = 1'b1;
            lrp_pkg::ST_FINISH:
            begin
                cmd.advance = finish_go;
                cmd.emit    = finish_go && status.hit;
            end
            default: cmd = '0;
        endcase
    end

    // Output word valid: set by a hit, cleared when the word is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish_go)
            out_valid_next = status.hit;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrp_pkg::ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted sample closes the input until its work is done.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input stayed open after a sample was accepted");

    // The shared loop always starts from step zero.
    a_iter_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrp_pkg::ST_REDUCE) |=> (iter_reg == '0))
        else $error("iteration counter not cleared at loop start");

    // A new pixel never overwrites a word the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("pixel word overwritten while pending");

    // A stalled receiver holds the controller in its last step.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrp_pkg::ST_FINISH && out_valid_reg && !out_ready)
        |=> (state_reg == lrp_pkg::ST_FINISH))
        else $error("controller left the last step while the output was stalled");

endmodule

`default_nettype wire

// ===== hdl/lrp_datapath.sv =====
// Datapath: angle state, CORDIC sine, range divider, row mapping and pixel register.
`default_nettype none

module lrp_datapath #(
    parameter int IMAGE_WIDTH      = lrp_pkg::IMAGE_WIDTH_DEFAULT,
    parameter int MAX_IMAGE_HEIGHT = lrp_pkg::MAX_IMAGE_HEIGHT_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lrp_pkg::lrp_cfg_t    cfg,
    input  wire lrp_pkg::lrp_cmd_t    cmd,
    output lrp_pkg::lrp_status_t      status,
    input  wire logic [15:0]          range_sample,
    input  wire logic                 last_in_frame,
    output logic [9:0]                pixel_row,
    output logic [9:0]                pixel_column,
    output logic [15:0]               pixel_value
);

    localparam int COL_W = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
    localparam logic [lrp_pkg::DIM_W-1:0] WIDTH_LIM  = lrp_pkg::DIM_W'(IMAGE_WIDTH);
    localparam logic [lrp_pkg::DIM_W-1:0] HEIGHT_LIM = lrp_pkg::DIM_W'(MAX_IMAGE_HEIGHT);

    // Scan state.
    logic [COL_W-1:0]          col_reg;
    logic [COL_W-1:0]          col_next;
    logic [23:0]               scan_cur_reg;
    logic [23:0]               scan_cur_next;
    logic [23:0]               stepper_cur_reg;
    logic [23:0]               stepper_cur_next;

    // Work registers for one sample.
    logic                      last_reg;
    logic signed [33:0]        x_reg;
    logic signed [33:0]        y_reg;
    logic signed [24:0]        z_reg;
    logic [31:0]               quot_reg;
    logic [15:0]               rem_reg;
    logic signed [55:0]        prod_reg;
    logic signed [25:0]        t_reg;
    logic signed [49:0]        d_reg;
    logic signed [15:0]        deg_reg;
    logic [9:0]                row_reg;
    logic                      hit_reg;
    logic [15:0]               value_reg;

    // Output word.
    logic [9:0]                pixel_row_reg;
    logic [9:0]                pixel_column_reg;
    logic [15:0]               pixel_value_reg;

    // Combinational helpers.
    logic [lrp_pkg::DIM_W-1:0] spp_eff;
    logic [lrp_pkg::DIM_W-1:0] height_eff;
    logic [15:0]               mr_eff;
    logic                      scan_end;
    logic signed [24:0]        ang_in;
    logic signed [24:0]        ang_wrap;
    logic signed [24:0]        ang_fold;
    logic signed [33:0]        xs;
    logic signed [33:0]        ys;
    logic signed [24:0]        atan_val;
    logic                      cordic_on;
    logic [16:0]               rem_sh;
    logic [16:0]               rem_diff;
    logic                      rem_ge;
    logic [49:0]               d_mag;
    logic [49:0]               d_rnd;
    logic signed [15:0]        row_full;

    // Clamped configuration values.
    always_comb
    begin
        if (cfg.samples_per_scan == 11'd0)
            spp_eff = lrp_pkg::DIM_W'(1);
        else if (lrp_pkg::DIM_W'(cfg.samples_per_scan) > WIDTH_LIM)
            spp_eff = WIDTH_LIM;
        else
            spp_eff = lrp_pkg::DIM_W'(cfg.samples_per_scan);

        if (lrp_pkg::DIM_W'(cfg.image_height) > HEIGHT_LIM)
            height_eff = HEIGHT_LIM;
        else
            height_eff = lrp_pkg::DIM_W'(cfg.image_height);

        mr_eff = (cfg.max_range == 16'd0) ? 16'd1 : cfg.max_range;
    end

    // Angle reduction into the range of the rotation, then folding to +-pi/2.
    always_comb
    begin
        ang_in = {scan_cur_reg[23], scan_cur_reg};
        if (ang_in > lrp_pkg::PI_Q20)
            ang_wrap = ang_in - lrp_pkg::TWO_PI_Q20;
        else if (ang_in < -lrp_pkg::PI_Q20)
            ang_wrap = ang_in + lrp_pkg::TWO_PI_Q20;
        else
            ang_wrap = ang_in;

        if (ang_wrap > lrp_pkg::HALF_PI_Q20)
            ang_fold = lrp_pkg::PI_Q20 - ang_wrap;
        else if (ang_wrap < -lrp_pkg::HALF_PI_Q20)
            ang_fold = -lrp_pkg::PI_Q20 - ang_wrap;
        else
            ang_fold = ang_wrap;
    end

    // One restoring divide step per loop cycle, plus one CORDIC rotation while the step index is below CORDIC_STEPS.
    always_comb
    begin
        xs        = x_reg >>> cmd.iter_idx;
        ys        = y_reg >>> cmd.iter_idx;
        atan_val  = lrp_pkg::atan_q20(cmd.iter_idx);
        cordic_on = (cmd.iter_idx < lrp_pkg::ITER_W'(lrp_pkg::CORDIC_STEPS));
        rem_sh    = {rem_reg, quot_reg[31]};
        rem_diff  = rem_sh - {1'b0, mr_eff};
        rem_ge    = (rem_sh >= {1'b0, mr_eff});
    end

    // Degree rounding, halves away from zero, and row mapping.
    always_comb
    begin
        d_mag    = d_reg[49] ? 50'(-d_reg) : 50'(d_reg);
        d_rnd    = (d_mag + (50'd1 << 35)) >> 36;
        row_full = $signed({3'b000, height_eff}) - deg_reg;
    end

    // Sample work registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            last_reg <= last_in_frame;
            quot_reg <= {range_sample, 16'h0000};
            rem_reg  <= '0;
        end
        if (cmd.reduce)
        begin
            x_reg <= lrp_pkg::CORDIC_X0;
            y_reg <= '0;
            z_reg <= ang_fold;
        end
        if (cmd.iter)
        begin
            if (cordic_on)
            begin
                if (!z_reg[24])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_val;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_val;
                end
            end
            rem_reg  <= rem_ge ? rem_diff[15:0] : rem_sh[15:0];
            quot_reg <= {quot_reg[30:0], rem_ge};
        end
        if (cmd.mul)
            prod_reg <= $signed(stepper_cur_reg) * $signed(y_reg[31:0]);
        if (cmd.sum)
            t_reg <= prod_reg[55:30] + {{2{cfg.endstop_angle[23]}}, cfg.endstop_angle};
        if (cmd.scale)
            d_reg <= t_reg * $signed({1'b0, lrp_pkg::DEG_Q16});
        if (cmd.round)
            deg_reg <= d_reg[49] ? -$signed(d_rnd[15:0]) : $signed(d_rnd[15:0]);
        if (cmd.check)
        begin
            row_reg   <= row_full[9:0];
            hit_reg   <= !row_full[15] && (row_full < $signed({3'b000, height_eff}));
            value_reg <= (|quot_reg[31:16]) ? 16'hFFFF : quot_reg[15:0];
        end
        if (cmd.emit)
        begin
            pixel_row_reg    <= row_reg;
            pixel_column_reg <= 10'(col_reg);
            pixel_value_reg  <= value_reg;
        end
    end

    // Scan position update at the end of each sample; a frame end wins over a scan end.
    always_comb
    begin
        scan_end         = (lrp_pkg::DIM_W'(col_reg) + 1'b1) >= spp_eff;
        col_next         = col_reg;
        scan_cur_next    = scan_cur_reg;
        stepper_cur_next = stepper_cur_reg;
        if (cmd.advance)
        begin
            if (last_reg)
            begin
                col_next         = '0;
                scan_cur_next    = cfg.scan_start_angle;
                stepper_cur_next = cfg.stepper_start_angle;
            end
            else if (scan_end)
            begin
                col_next         = '0;
                scan_cur_next    = cfg.scan_start_angle;
                stepper_cur_next = stepper_cur_reg + cfg.stepper_angle_step;
            end
            else
            begin
                col_next      = col_reg + 1'b1;
                scan_cur_next = scan_cur_reg + cfg.scan_angle_step;
            end
        end
    end

    // Scan state registers; start angles reset to zero like their registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            scan_cur_reg    <= '0;
            stepper_cur_reg <= '0;
        end
        else
        begin
            col_reg         <= col_next;
            scan_cur_reg    <= scan_cur_next;
            stepper_cur_reg <= stepper_cur_next;
        end
    end

    assign status.hit   = hit_reg;
    assign pixel_row    = pixel_row_reg;
    assign pixel_column = pixel_column_reg;
    assign pixel_value  = pixel_value_reg;

endmodule

`default_nettype wire

// ===== hdl/lidar_range_to_projection.sv =====
// Top level of the lidar range-to-projection pixel generator.
//
// Use: range samples come in on the sample channel, one word per lidar
// return, with last_in_frame marking the final sample of a frame. For each
// sample the block finds the image row from the stepper angle, the sine of the
// in-scan angle and the endstop angle, and sends a pixel word (row, column,
// range scaled by max_range) on the pixel channel when the row falls inside the
// image. Samples whose row is outside the image produce no word, but they still
// advance the column and the scan angle.
// Configuration registers are written on the cfg channel, which is always
// ready; write them only while no sample is in flight.
// A pixel word, if any, becomes valid in the same cycle as the sample channel
// opens again; a new sample is not accepted while one is being worked on.
// Each sample passes through acceptance, angle reduction, the 32-step
// restoring divider for the pixel value, which shares its step counter with
// the 20 CORDIC rotations, then multiply, sum, scaling, rounding, row check
// and output.
// A stalled receiver holds the pending pixel word; the next sample is still
// accepted and worked on, and waits in its last step until the word is taken.
// Reset clears the column and both running angles and loads the register
// reset values; no sample is pending afterwards.
`default_nettype none

module lidar_range_to_projection #(
    parameter int IMAGE_WIDTH      = lrp_pkg::IMAGE_WIDTH_DEFAULT,
    parameter int MAX_IMAGE_HEIGHT = lrp_pkg::MAX_IMAGE_HEIGHT_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    lrp_sample_if.sink   sample,
    lrp_pixel_if.source  pixel,
    lrp_cfg_if.sink      cfg
);

    lrp_pkg::lrp_cfg_t    cfg_regs;
    lrp_pkg::lrp_cmd_t    cmd;
    lrp_pkg::lrp_status_t status;

    // Configuration registers.
    lrp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .wr_ready (cfg.ready),
        .cfg      (cfg_regs)
    );

    // Sequencer.
    lrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (pixel.valid),
        .out_ready (pixel.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and scan state.
    lrp_datapath #(
        .IMAGE_WIDTH      (IMAGE_WIDTH),
        .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_regs),
        .cmd           (cmd),
        .status        (status),
        .range_sample  (sample.range_sample),
        .last_in_frame (sample.last_in_frame),
        .pixel_row     (pixel.pixel_row),
        .pixel_column  (pixel.pixel_column),
        .pixel_value   (pixel.pixel_value)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the lidar range-to-projection block, with a bit-exact pixel predictor.
`timescale 1ns / 100ps

module testbench;

    // Block geometry and fixed-point constants used by the pixel predictor.
    localparam int     IMAGE_W         = lrp_pkg::IMAGE_WIDTH_DEFAULT;
    localparam int     MAX_H           = lrp_pkg::MAX_IMAGE_HEIGHT_DEFAULT;
    localparam longint ANG_PI          = 64'sd3294199;
    localparam longint ANG_2PI         = 64'sd6588397;
    localparam longint ANG_HALF_PI     = 64'sd1647099;
    localparam longint SINE_X0         = 64'sd652032875;
    localparam longint DEG_PER_RAD_Q16 = 64'sd3754936;
    localparam longint ROUND_HALF      = 64'sd34359738368;
    localparam int     Q20_PER_DEG     = 18301;

    // Run control.
    localparam int SETTLE_CYCLES   = 60;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 55;

    typedef struct {
        logic [15:0] range_sample;
        logic        last_in_frame;
    } range_word_t;

    typedef struct {
        logic [9:0]  row;
        logic [9:0]  column;
        logic [15:0] value;
    } pixel_word_t;

    logic clk = 1'b0;
    logic rst_n;

    lrp_sample_if sample_ch ();
    lrp_pixel_if  pixel_ch ();
    lrp_cfg_if    cfg_ch ();

    lidar_range_to_projection dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .pixel (pixel_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // Arctangent of 2^-k in Q20 radians, one entry per rotation.
    longint atan_tbl [20] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    // Register copy and running state of the predictor.
    lrp_pkg::lrp_cfg_t shadow_cfg;
    logic [9:0] col_pos;
    logic [23:0] scan_ang;
    logic [23:0] stepper_ang;

    range_word_t pending_ranges [$];
    pixel_word_t expected_pixels [$];
    int          words_outstanding = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    logic        hold_sender = 1'b0;

    function automatic longint sx24(input logic [23:0] v);
        return longint'($signed(v));
    endfunction

    // Sine in Q30 of a Q20 angle: fold into [-pi/2, pi/2], then 20 CORDIC rotations.
    function automatic longint sine_q30(input longint ang);
        longint x, y, z, xs, ys;
        x = SINE_X0;
        y = 0;
        while (ang > ANG_PI) ang -= ANG_2PI;
        while (ang < -ANG_PI) ang += ANG_2PI;
        if (ang > ANG_HALF_PI)
            ang = ANG_PI - ang;
        else if (ang < -ANG_HALF_PI)
            ang = -ANG_PI - ang;
        z = ang;
        for (int k = 0; k < 20; k++)
        begin
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tbl[k];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tbl[k];
            end
        end
        return y;
    endfunction

    // Work out the pixel word for one accepted range word and advance the angles.
    task automatic predict_pixel(input logic [15:0] rng, input logic last);
        int          scan_len, rows;
        longint      t, d, deg, row, val, divisor;
        pixel_word_t p;
        scan_len = shadow_cfg.samples_per_scan;
        if (scan_len == 0) scan_len = 1;
        if (scan_len > IMAGE_W) scan_len = IMAGE_W;
        rows = shadow_cfg.image_height;
        if (rows > MAX_H) rows = MAX_H;

        t = ((sx24(stepper_ang) * sine_q30(sx24(scan_ang))) >>> 30)
            + sx24(shadow_cfg.endstop_angle);
        d = t * DEG_PER_RAD_Q16;
        // Degrees are rounded with halves away from zero.
        if (d >= 0)
            deg = (d + ROUND_HALF) >>> 36;
        else
            deg = -((-d + ROUND_HALF) >>> 36);
        row = rows - deg;

        if (row >= 0 && row < rows)
        begin
            divisor = (shadow_cfg.max_range == 16'd0) ? 1 : longint'(shadow_cfg.max_range);
            val = (longint'(rng) << 16) / divisor;
            if (val > 65535) val = 65535;
            p.row = 10'(row);
            p.column = col_pos;
            p.value = 16'(val);
            expected_pixels.push_back(p);
        end

        scan_ang = scan_ang + shadow_cfg.scan_angle_step;
        // A frame end reloads both angles even in the middle of a scan.
        if (last)
        begin
            col_pos = '0;
            scan_ang = shadow_cfg.scan_start_angle;
            stepper_ang = shadow_cfg.stepper_start_angle;
        end
        else if (int'(col_pos) + 1 >= scan_len)
        begin
            col_pos = '0;
            scan_ang = shadow_cfg.scan_start_angle;
            stepper_ang = stepper_ang + shadow_cfg.stepper_angle_step;
        end
        else
        begin
            col_pos = col_pos + 10'd1;
        end
    endtask

    task automatic push_range(input logic [15:0] rng, input logic last);
        range_word_t w;
        w.range_sample = rng;
        w.last_in_frame = last;
        pending_ranges.push_back(w);
        words_outstanding++;
    endtask

    // Wait until every word is taken and every pixel has come, then let the last one settle.
    task automatic drain_idle();
        while (words_outstanding != 0 || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode % 4)
            0:
            begin
                gap_pct <= 0;
                stall_pct <= 0;
            end
            1:
            begin
                gap_pct <= 58;
                stall_pct <= 0;
            end
            2:
            begin
                gap_pct <= 0;
                stall_pct <= 58;
            end
            default:
            begin
                gap_pct <= 34;
                stall_pct <= 34;
            end
        endcase
    endtask

    // Write all registers back to back; unused upper data bits carry random junk.
    task automatic program_regs(input lrp_pkg::lrp_cfg_t c);
        lrp_pkg::cfg_index_t idx;
        logic [23:0]         word;
        idx = idx.first();
        repeat (idx.num())
        begin
            case (idx)
                lrp_pkg::REG_SAMPLES_PER_SCAN:    word = {13'($urandom), c.samples_per_scan};
                lrp_pkg::REG_SCAN_START_ANGLE:    word = c.scan_start_angle;
                lrp_pkg::REG_SCAN_ANGLE_STEP:     word = c.scan_angle_step;
                lrp_pkg::REG_MAX_RANGE:           word = {8'($urandom), c.max_range};
                lrp_pkg::REG_STEPPER_START_ANGLE: word = c.stepper_start_angle;
                lrp_pkg::REG_STEPPER_ANGLE_STEP:  word = c.stepper_angle_step;
                lrp_pkg::REG_ENDSTOP_ANGLE:       word = c.endstop_angle;
                default:                          word = {13'($urandom), c.image_height};
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data <= word;
            do @(posedge clk); while (!cfg_ch.ready);
            idx = idx.next();
        end
        cfg_ch.valid <= 1'b0;
        shadow_cfg = c;
    endtask

    // Random settings, mostly placed so that the rows land inside the image.
    function automatic lrp_pkg::lrp_cfg_t random_cfg();
        lrp_pkg::lrp_cfg_t c;
        int unsigned       rows, amp, es;
        case ($urandom_range(0, 9))
            0:       c.samples_per_scan = 11'($urandom_range(0, 2047));
            1:       c.samples_per_scan = 11'($urandom_range(41, 1024));
            default: c.samples_per_scan = 11'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 9))
            0:       rows = $urandom_range(0, 2047);
            1:       rows = $urandom_range(1, 15);
            default: rows = $urandom_range(16, 1024);
        endcase
        c.image_height = 11'(rows);
        if (rows > MAX_H) rows = MAX_H;
        c.max_range = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 255))
                                                   : 16'($urandom);
        c.scan_start_angle = 24'($urandom);
        c.scan_angle_step = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                          : 24'($urandom_range(0, 400000) - 200000);
        es = $urandom_range(0, rows) * Q20_PER_DEG;
        if (es > 8388607) es = 8388607;
        c.endstop_angle = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'(es);
        amp = rows * (Q20_PER_DEG / 4) + 1;
        if (amp > 8388607) amp = 8388607;
        c.stepper_start_angle = ($urandom_range(0, 5) == 0) ? 24'($urandom)
                              : 24'($urandom_range(0, 2 * amp) - amp);
        c.stepper_angle_step = ($urandom_range(0, 5) == 0) ? 24'($urandom)
                             : 24'($urandom_range(0, 200000) - 100000);
        return c;
    endfunction

    function automatic logic [15:0] random_range(input logic [15:0] mr);
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            1:       return mr + 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue whole frames of scans; now and then a frame ends early inside a scan.
    task automatic queue_random_frames(input lrp_pkg::lrp_cfg_t c);
        int queued, scan_len, frame_len, cut;
        queued = 0;
        scan_len = c.samples_per_scan;
        if (scan_len == 0) scan_len = 1;
        if (scan_len > IMAGE_W) scan_len = IMAGE_W;
        while (queued < WORDS_PER_PHASE)
        begin
            frame_len = scan_len * $urandom_range(1, 3);
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, frame_len) : frame_len;
            for (int k = 1; k <= cut && queued < WORDS_PER_PHASE + 15; k++)
            begin
                push_range(random_range(c.max_range), k == cut);
                queued++;
            end
        end
    endtask

    // Range word driver: predicts on each accepted word, then offers the next one.
    always @(posedge clk or negedge rst_n)
    begin : drive_ranges
        range_word_t w;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.range_sample <= '0;
            sample_ch.last_in_frame <= 1'b0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                predict_pixel(sample_ch.range_sample, sample_ch.last_in_frame);
                words_outstanding--;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (pending_ranges.size() != 0 && !hold_sender &&
                    $urandom_range(0, 99) >= gap_pct)
                begin
                    w = pending_ranges.pop_front();
                    sample_ch.valid <= 1'b1;
                    sample_ch.range_sample <= w.range_sample;
                    sample_ch.last_in_frame <= w.last_in_frame;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Pixel word monitor: compares each taken word with the oldest expected one.
    always @(posedge clk or negedge rst_n)
    begin : check_pixels
        pixel_word_t want;
        if (!rst_n)
        begin
            pixel_ch.ready <= 1'b0;
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel word, row %0d column %0d value %0d", $time,
                             pixel_ch.pixel_row, pixel_ch.pixel_column, pixel_ch.pixel_value);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_ch.pixel_row !== want.row)
                    begin
                        $display("%0t: pixel_row expected %0d actual %0d", $time,
                                 want.row, pixel_ch.pixel_row);
                        mismatch_count++;
                    end
                    if (pixel_ch.pixel_column !== want.column)
                    begin
                        $display("%0t: pixel_column expected %0d actual %0d", $time,
                                 want.column, pixel_ch.pixel_column);
                        mismatch_count++;
                    end
                    if (pixel_ch.pixel_value !== want.value)
                    begin
                        $display("%0t: pixel_value expected %0d actual %0d", $time,
                                 want.value, pixel_ch.pixel_value);
                        mismatch_count++;
                    end
                end
            end
            pixel_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        lrp_pkg::lrp_cfg_t c;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = lrp_pkg::REG_SAMPLES_PER_SCAN;
        cfg_ch.data = '0;
        shadow_cfg = '{samples_per_scan: 11'd1024, scan_start_angle: 24'd0,
                       scan_angle_step: 24'd0, max_range: 16'd65535,
                       stepper_start_angle: 24'd0, stepper_angle_step: 24'd0,
                       endstop_angle: 24'd0, image_height: 11'd1024};
        col_pos = '0;
        scan_ang = '0;
        stepper_ang = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: the row lands exactly on the image height, so nothing comes out.
        push_range(16'd0, 1'b0);
        push_range(16'hFFFF, 1'b0);
        drain_idle();

        // Zero scan length, zero max range, tall image, extreme scan angles.
        set_idle(0);
        c = '{samples_per_scan: 11'd0, scan_start_angle: 24'h800000,
              scan_angle_step: 24'h7FFFFF, max_range: 16'd0,
              stepper_start_angle: 24'd1000000, stepper_angle_step: 24'd300000,
              endstop_angle: 24'd1830100, image_height: 11'd2047};
        program_regs(c);
        push_range(16'd0, 1'b0);
        push_range(16'hFFFF, 1'b0);
        push_range(16'd1, 1'b1);
        push_range(16'd32768, 1'b0);
        push_range(16'hFFFF, 1'b1);
        drain_idle();

        // Long scan and zero height: no pixel words at all.
        set_idle(1);
        c = '{samples_per_scan: 11'd2047, scan_start_angle: 24'd0,
              scan_angle_step: 24'd100000, max_range: 16'hFFFF,
              stepper_start_angle: 24'd0, stepper_angle_step: 24'd0,
              endstop_angle: 24'd0, image_height: 11'd0};
        program_regs(c);
        push_range(16'd100, 1'b0);
        push_range(16'd200, 1'b0);
        push_range(16'd300, 1'b1);
        drain_idle();

        // Frame end inside a scan, saturated value, extreme endstop and stepper.
        set_idle(2);
        c = '{samples_per_scan: 11'd5, scan_start_angle: 24'd500000,
              scan_angle_step: 24'd200000, max_range: 16'd1,
              stepper_start_angle: 24'h800000, stepper_angle_step: 24'h800000,
              endstop_angle: 24'h7FFFFF, image_height: 11'd1024};
        program_regs(c);
        push_range(16'd0, 1'b0);
        push_range(16'd1, 1'b0);
        push_range(16'hFFFF, 1'b1);
        push_range(16'd7, 1'b0);
        push_range(16'd8, 1'b0);
        drain_idle();

        // Small image with rows near both edges.
        set_idle(3);
        c = '{samples_per_scan: 11'd3, scan_start_angle: 24'd1647099,
              scan_angle_step: 24'hFB6C20, max_range: 16'hFFFF,
              stepper_start_angle: 24'd20000, stepper_angle_step: 24'd15000,
              endstop_angle: 24'd292818, image_height: 11'd16};
        program_regs(c);
        push_range(16'hFFFF, 1'b0);
        push_range(16'hFFFE, 1'b0);
        push_range(16'd1, 1'b0);
        push_range(16'd12345, 1'b0);
        push_range(16'd54321, 1'b1);
        drain_idle();

        // Random settings with frames of random range words.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_idle(phase);
            c = random_cfg();
            program_regs(c);
            queue_random_frames(c);
            if (phase == 5)
            begin
                // Hold the sender until every pending pixel word has arrived.
                while (words_outstanding > 30)
                    @(posedge clk);
                hold_sender <= 1'b1;
                do @(posedge clk); while (sample_ch.valid || expected_pixels.size() != 0);
                hold_sender <= 1'b0;
            end
            drain_idle();
        end

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
